// ===== src/mct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_pkg
// Shared types and constants of the one-shot timer table.
// ----------------------------------------------------------------------------
package mct_pkg;

  localparam int unsigned NUM_TIMERS_DEF = 16;
  localparam int unsigned IDX_W          = 4;
  localparam int unsigned CNT_W          = 5;
  localparam int unsigned IVAL_W         = 32;
  localparam int unsigned TIME_W         = 64;
  localparam int unsigned PROD_W         = 42;
  localparam logic [PROD_W-1:0] US_PER_MS = PROD_W'(1000);
  localparam logic [TIME_W-1:0] TIME_MAX  = '1;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_QUERY  = 2'd2,
    OP_SCAN   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_LAUNCH,
    ST_SWEEP,
    ST_DONE
  } state_t;

  // broadcast command to every cell
  typedef struct packed {
    logic               upd;
    op_t                op;
    logic [IDX_W-1:0]   idx;
    logic [TIME_W-1:0]  now;
    logic [TIME_W-1:0]  deadline;
    logic               ival_zero;
  } cmd_t;

  // token handed from cell to cell during the sweep
  typedef struct packed {
    logic               vld;
    logic               found;
    logic [TIME_W-1:0]  best;
    logic [CNT_W-1:0]   hits;
  } tok_t;

endpackage

// ===== src/mct_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_in_if
// Command channel: opcode, timer index, interval and current time.
// ----------------------------------------------------------------------------
interface mct_in_if
  import mct_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [IDX_W-1:0]    timer_index;
  logic [IVAL_W-1:0]   delay_ms;
  logic [TIME_W-1:0]   now_us;

  modport source (output valid, opcode, timer_index, delay_ms, now_us, input ready);
  modport sink   (input valid, opcode, timer_index, delay_ms, now_us, output ready);
endinterface

// ===== src/mct_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_out_if
// Status channel: selected flags, count, earliest deadline and alarm flags.
// ----------------------------------------------------------------------------
interface mct_out_if
  import mct_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic                sel_expired;
  logic                sel_active;
  logic [CNT_W-1:0]    active_total;
  logic [TIME_W-1:0]   earliest_deadline;
  logic                alarm_armed;
  logic                force_alarm;
  logic                past_due;

  modport source (output valid, sel_expired, sel_active, active_total, earliest_deadline,
                  alarm_armed, force_alarm, past_due, input ready);
  modport sink   (input valid, sel_expired, sel_active, active_total, earliest_deadline,
                  alarm_armed, force_alarm, past_due, output ready);
endinterface

// ===== src/multi_channel_oneshot_timer.sv =====
`timescale 1ns / 1ps
// Steps: each accepted command passes ST_MUL, ST_UPD and ST_DONE; set (valid
//   index), cancel of an active timer and scan also pass ST_LAUNCH and ST_SWEEP.
// Commands are taken one at a time, once the last has reached ST_DONE;
//   the earliest-deadline token walks the cell chain one cell per cycle. A new
//   command is taken while the previous status word waits at the output.
// Reset: synchronous, active low; all timers idle, earliest deadline all ones.
// ----------------------------------------------------------------------------
// multi_channel_oneshot_timer
// Table of one-shot timers with set, cancel, query and alarm scan commands.
// ----------------------------------------------------------------------------
module multi_channel_oneshot_timer
  import mct_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mct_in_if.sink     in_ch,
  mct_out_if.source  out_ch
);

  state_t             state_r, state_nxt;

  op_t                op_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IVAL_W-1:0]  ival_r;
  logic [TIME_W-1:0]  now_r;
  logic [PROD_W-1:0]  prod_r;

  logic [CNT_W-1:0]   cnt_r;
  logic [TIME_W-1:0]  earliest_r;
  logic               armed_r;
  logic               force_r;
  logic               recomp;

  logic               out_valid_r;
  logic               out_sel_exp_r;
  logic               out_sel_act_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic [TIME_W-1:0]  out_earliest_r;
  logic               out_armed_r;
  logic               out_force_r;
  logic               out_past_r;

  cmd_t               cmd;
  tok_t               tok [NUM_TIMERS+1];
  logic [NUM_TIMERS-1:0] act_v;
  logic [NUM_TIMERS-1:0] exp_v;

  logic               idx_ok;
  logic               sel_act;
  logic               sel_exp;
  logic               accept;
  logic               out_free;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign idx_ok   = (32'(idx_r) < NUM_TIMERS);
  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    sel_act = 1'b0;
    sel_exp = 1'b0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (32'(idx_r) == i) begin
        sel_act = act_v[i];
        sel_exp = exp_v[i];
      end
    end
  end

  assign recomp = (op_r == OP_SCAN) ||
                  ((op_r == OP_SET) && idx_ok) ||
                  ((op_r == OP_CANCEL) && idx_ok && sel_act);

  always_comb begin
    cmd.upd       = (state_r == ST_UPD);
    cmd.op        = op_r;
    cmd.idx       = idx_r;
    cmd.now       = now_r;
    cmd.deadline  = now_r + TIME_W'(prod_r);
    cmd.ival_zero = (ival_r == '0);
  end

  always_comb begin
    tok[0].vld   = (state_r == ST_LAUNCH);
    tok[0].found = 1'b0;
    tok[0].best  = TIME_MAX;
    tok[0].hits  = '0;
  end

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    mct_cell #(.CELL_IDX(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1]),
      .active  (act_v[g]),
      .expired (exp_v[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_UPD;
      ST_UPD:    state_nxt = recomp ? ST_LAUNCH : ST_DONE;
      ST_LAUNCH: state_nxt = ST_SWEEP;
      ST_SWEEP:  if (tok[NUM_TIMERS].vld) state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_ch.opcode);
      idx_r  <= in_ch.timer_index;
      ival_r <= in_ch.delay_ms;
      now_r  <= in_ch.now_us;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(ival_r) * US_PER_MS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      earliest_r <= TIME_MAX;
      armed_r    <= 1'b0;
      force_r    <= 1'b0;
    end else begin
      if (state_r == ST_UPD) begin
        force_r <= 1'b0;
        if ((op_r == OP_SET) && idx_ok && !sel_act) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end else if ((op_r == OP_CANCEL) && idx_ok && sel_act) begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
      if ((state_r == ST_SWEEP) && tok[NUM_TIMERS].vld) begin
        earliest_r <= tok[NUM_TIMERS].best;
        armed_r    <= tok[NUM_TIMERS].found;
        force_r    <= tok[NUM_TIMERS].found && (tok[NUM_TIMERS].best <= now_r);
        cnt_r      <= cnt_r - tok[NUM_TIMERS].hits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_sel_exp_r  <= idx_ok && sel_exp;
      out_sel_act_r  <= idx_ok && sel_act;
      out_cnt_r      <= cnt_r;
      out_earliest_r <= earliest_r;
      out_armed_r    <= armed_r;
      out_force_r    <= force_r;
      out_past_r     <= (now_r > earliest_r);
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.sel_expired       = out_sel_exp_r;
  assign out_ch.sel_active        = out_sel_act_r;
  assign out_ch.active_total      = out_cnt_r;
  assign out_ch.earliest_deadline = out_earliest_r;
  assign out_ch.alarm_armed       = out_armed_r;
  assign out_ch.force_alarm       = out_force_r;
  assign out_ch.past_due          = out_past_r;

endmodule

// ===== src/mct_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_cell
// One timer entry: deadline, active and expired flags, and one stage of the
// earliest-deadline token chain.
// ----------------------------------------------------------------------------
module mct_cell
  import mct_pkg::*;
#(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cmd_t  cmd,
  input  tok_t  tok_in,
  output tok_t  tok_out,
  output logic  active,
  output logic  expired
);

  logic [TIME_W-1:0] deadline_r;
  logic              active_r;
  logic              expired_r;
  logic              hit_r;
  tok_t              tok_r;

  logic              mine;
  logic              live;
  logic              due;
  logic              take;

  assign mine = (32'(cmd.idx) == 32'(CELL_IDX));
  assign live = active_r && !expired_r;
  assign due  = live && (cmd.now >= deadline_r);
  assign take = live && (!tok_in.found || (deadline_r < tok_in.best));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      expired_r <= 1'b0;
      hit_r     <= 1'b0;
    end else if (cmd.upd) begin
      hit_r <= 1'b0;
      case (cmd.op)
        OP_SET: begin
          if (mine) begin
            active_r  <= 1'b1;
            expired_r <= cmd.ival_zero;
          end
        end
        OP_CANCEL: begin
          if (mine && active_r) begin
            active_r  <= 1'b0;
            expired_r <= 1'b0;
          end
        end
        OP_SCAN: begin
          if (due) begin
            active_r  <= 1'b0;
            expired_r <= 1'b1;
            hit_r     <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && (cmd.op == OP_SET) && mine) begin
      deadline_r <= cmd.deadline;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r.vld   <= tok_in.vld;
      tok_r.found <= tok_in.found || live;
      tok_r.best  <= take ? deadline_r : tok_in.best;
      tok_r.hits  <= tok_in.hits + CNT_W'(hit_r);
    end
  end

  assign tok_out = tok_r;
  assign active  = active_r;
  assign expired = expired_r;

endmodule

// ===== src/mct_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_checker
// Port-level checks of the timer table, bound to the top level.
// ----------------------------------------------------------------------------
module mct_checker
  import mct_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [TIME_W-1:0]  earliest_deadline,
  input logic               alarm_armed,
  input logic               force_alarm,
  input logic               past_due
);

  // one command in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted while previous one still in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(earliest_deadline) &&
                                $stable(force_alarm))
    else $error("status word dropped or changed while stalled");

  a_idle_deadline: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !alarm_armed |-> (earliest_deadline == TIME_MAX) && !past_due)
    else $error("disarmed alarm with a live deadline");

  a_force_armed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && force_alarm |-> alarm_armed)
    else $error("forced alarm without an armed timer");

endmodule

bind multi_channel_oneshot_timer mct_checker u_mct_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .earliest_deadline (out_ch.earliest_deadline),
  .alarm_armed       (out_ch.alarm_armed),
  .force_alarm       (out_ch.force_alarm),
  .past_due          (out_ch.past_due)
);
